// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL files; fcbv_cell includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/fcbv_pkg.sv =====
package fcbv_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int COORD_FRAC      = 8;
  localparam int NORM_FRAC       = 14;
  localparam int NUM_PLANES      = 6;
  localparam int STAGES_PER_CELL = 4;
  localparam int ADDR_WIDTH      = 6;
  localparam int REG_SEL_LSB     = 3;

  typedef enum logic [1:0] {
    FUNC_SPHERE    = 2'd0,
    FUNC_CIRCLE    = 2'd1,
    FUNC_ELLIPSE   = 2'd2,
    FUNC_ELLIPSOID = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [5:0]  plane_mask;
    logic [47:0] center;
    logic [47:0] axis_a;
    logic [47:0] axis_b;
    logic [47:0] axis_c;
    logic [15:0] radius;
    logic        vis;
  } item_t;

endpackage

// ===== src/fcbv_if.sv =====
interface fcbv_bv_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  plane_mask;
  logic [47:0] center;
  logic [47:0] axis_a;
  logic [47:0] axis_b;
  logic [47:0] axis_c;
  logic [15:0] radius;

  modport source (output valid, func, plane_mask, center, axis_a, axis_b, axis_c, radius,
                  input ready);
  modport sink (input valid, func, plane_mask, center, axis_a, axis_b, axis_c, radius,
                output ready);
endinterface

interface fcbv_res_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// ===== src/frustum_cull_bounding_volume.sv =====
// Frustum culling of a stream of bounding volumes against six planes.
// Planes are written through the APB port: register i at byte address 8*i,
// 64 bits each, normal components Q1.14 in bits 47:0 and distance in 63:48.
// Write planes only while no item is in flight. Reads return the plane.
// Items enter on the bv channel (valid/ready) and give one visible bit each
// on the res channel, in order.
// A row of six cells, one per plane, carries each item; every cell is a
// four-stage pipeline (products, dot sums, squares, compare), and one item
// is taken per cycle while the res channel is not stalling the row.
// Each stage advances whenever the stage after it can take its contents,
// so a stalled receiver only stops the stages that are full behind it;
// input ready falls once the whole row is full.
// Reset empties the row and clears all six planes to zero.
module frustum_cull_bounding_volume #(
  parameter int COORD_WIDTH = fcbv_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  fcbv_bv_if.sink                           bv,
  fcbv_res_if.source                        res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fcbv_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready
);
  import fcbv_pkg::*;

  logic [63:0] plane [NUM_PLANES];
  logic [ADDR_WIDTH-REG_SEL_LSB-1:0] reg_sel;

  logic  c_valid [NUM_PLANES+1];
  logic  c_ready [NUM_PLANES+1];
  item_t c_item  [NUM_PLANES+1];

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_WIDTH-1:REG_SEL_LSB];
  assign prdata  = (reg_sel < NUM_PLANES) ? plane[reg_sel] : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane[i] <= 64'd0;
      end
    end else if (psel && penable && pwrite && (reg_sel < NUM_PLANES)) begin
      plane[reg_sel] <= pwdata;
    end
  end

  assign c_valid[0]            = bv.valid;
  assign bv.ready              = c_ready[0];
  assign c_item[0].func        = func_t'(bv.func);
  assign c_item[0].plane_mask  = bv.plane_mask;
  assign c_item[0].center      = bv.center;
  assign c_item[0].axis_a      = bv.axis_a;
  assign c_item[0].axis_b      = bv.axis_b;
  assign c_item[0].axis_c      = bv.axis_c;
  assign c_item[0].radius      = bv.radius;
  assign c_item[0].vis         = 1'b1;

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    fcbv_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .plane     (plane[i]),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_item   (c_item[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_item  (c_item[i+1])
    );
  end

  assign res.valid           = c_valid[NUM_PLANES];
  assign res.visible         = c_item[NUM_PLANES].vis;
  assign c_ready[NUM_PLANES] = res.ready;

endmodule

// ===== src/fcbv_cell.sv =====
`include "assert_macros.svh"

module fcbv_cell #(
  parameter int COORD_WIDTH = fcbv_pkg::COORD_WIDTH_DEF,
  parameter int IDX         = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         plane,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcbv_pkg::item_t     in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output fcbv_pkg::item_t     out_item
);
  import fcbv_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int MW  = W + 16;
  localparam int PW  = W + 18;
  localparam int SW  = ((PW > 30) ? PW : 30) + 1;
  localparam int CMW = (((SW + COORD_FRAC) > (PW + 16)) ? (SW + COORD_FRAC) : (PW + 16)) + 2;
  localparam int QW  = ((2 * SW) > (2 * PW + 2)) ? (2 * SW) : (2 * PW + 2);
  localparam int EW  = ((3 * W) > 48) ? (3 * W) : 48;
  localparam int NS  = STAGES_PER_CELL;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  item_t         it [NS];
  item_t         it3_next;

  logic [EW-1:0] ce, ae, be, xe;
  logic signed [W-1:0]  cc [3], ca [3], cb [3], cx [3];
  logic signed [15:0]   nrm [3];
  logic signed [15:0]   plane_dist;

  logic signed [MW-1:0] prod_c [3], prod_a [3], prod_b [3], prod_x [3];

  logic signed [SW-1:0] s;
  logic signed [PW-1:0] pa, pb, pc;

  logic [PW-1:0]        ma, mb, mc;
  logic [SW-1:0]        ms;
  logic signed [SW+1:0] sph_sum;

  logic [2*PW-1:0]      sq_a, sq_b, sq_c;
  logic [2*SW-1:0]      s2;
  logic [PW+15:0]       circ;
  logic                 sph_rej;
  logic signed [SW-1:0] s_d;

  logic signed [CMW-1:0] circ_sum;
  logic [QW-1:0]         q2, q3;
  logic                  rej;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];
  assign out_item  = it[NS-1];

  assign ce         = EW'(in_item.center);
  assign ae         = EW'(in_item.axis_a);
  assign be         = EW'(in_item.axis_b);
  assign xe         = EW'(in_item.axis_c);
  assign plane_dist = signed'(plane[63:48]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cc[k]  = signed'(ce[k*W +: W]);
      ca[k]  = signed'(ae[k*W +: W]);
      cb[k]  = signed'(be[k*W +: W]);
      cx[k]  = signed'(xe[k*W +: W]);
      nrm[k] = signed'(plane[16*k +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      it[0] <= in_item;
      for (int k = 0; k < 3; k++) begin
        prod_c[k] <= MW'(nrm[k]) * MW'(cc[k]);
        prod_a[k] <= MW'(nrm[k]) * MW'(ca[k]);
        prod_b[k] <= MW'(nrm[k]) * MW'(cb[k]);
        prod_x[k] <= MW'(nrm[k]) * MW'(cx[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      it[1] <= it[0];
      s  <= SW'(prod_c[0]) + SW'(prod_c[1]) + SW'(prod_c[2]) + (SW'(plane_dist) <<< NORM_FRAC);
      pa <= PW'(prod_a[0]) + PW'(prod_a[1]) + PW'(prod_a[2]);
      pb <= PW'(prod_b[0]) + PW'(prod_b[1]) + PW'(prod_b[2]);
      pc <= PW'(prod_x[0]) + PW'(prod_x[1]) + PW'(prod_x[2]);
    end
  end

  always_comb begin
    ma = pa[PW-1] ? PW'(-pa) : PW'(pa);
    mb = pb[PW-1] ? PW'(-pb) : PW'(pb);
    mc = pc[PW-1] ? PW'(-pc) : PW'(pc);
    ms = s[SW-1] ? SW'(-s) : SW'(s);
    sph_sum = (SW+2)'(s) + ((SW+2)'(signed'({1'b0, it[1].radius})) <<< NORM_FRAC);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      it[2]   <= it[1];
      sq_a    <= (2*PW)'(ma) * (2*PW)'(ma);
      sq_b    <= (2*PW)'(mb) * (2*PW)'(mb);
      sq_c    <= (2*PW)'(mc) * (2*PW)'(mc);
      s2      <= (2*SW)'(ms) * (2*SW)'(ms);
      circ    <= (PW+16)'(it[1].radius) * (PW+16)'(ma);
      sph_rej <= sph_sum < 0;
      s_d     <= s;
    end
  end

  always_comb begin
    circ_sum = ((CMW)'(s_d) <<< COORD_FRAC) + CMW'(signed'({1'b0, circ}));
    q2 = QW'(sq_a) + QW'(sq_b);
    q3 = QW'(sq_a) + QW'(sq_b) + QW'(sq_c);
    case (it[2].func)
      FUNC_SPHERE:    rej = sph_rej;
      FUNC_CIRCLE:    rej = circ_sum < 0;
      FUNC_ELLIPSE:   rej = s_d[SW-1] && (QW'(s2) > q2);
      FUNC_ELLIPSOID: rej = (s_d <= 0) && (QW'(s2) >= q3);
      default:        rej = 1'b0;
    endcase
  end

  always_comb begin
    it3_next     = it[2];
    it3_next.vis = it[2].vis && !(it[2].plane_mask[IDX] && rej);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      it[3] <= it3_next;
    end
  end

  `ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && in_ready, v[0], "accepted item lost")
  `ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid, "stalled item dropped")
  `ASSERT_NEXT(a_stall_vis, clk, rst, out_valid && !out_ready, $stable(out_item.vis),
               "stalled result changed")
  `ASSERT_HOLDS(a_no_revive, clk, rst, (v[3] && !it[3].vis) |-> ($past(en[3]) ||
                !$past(it[3].vis)), "visibility set by a cell")

endmodule
